>>> design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define FPCM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define FPCM_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/fpcm_pkg.sv
// Shared constants and types of the five-point cross mean filter.
`default_nettype none

package fpcm_pkg;

  localparam int MAX_ROW_LENGTH_DEF = 2048;
  localparam int SAMPLE_W           = 16;
  localparam int ROW_LENGTH_W       = 12;
  localparam int ROW_COUNT_W        = 16;
  localparam int CFG_IDX_W          = 1;
  localparam int CFG_DATA_W         = 16;
  localparam int MIN_DIM            = 3;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT  = 1'b1;

  localparam logic [ROW_LENGTH_W-1:0] ROW_LENGTH_RST = 12'd2048;
  localparam logic [ROW_COUNT_W-1:0]  ROW_COUNT_RST  = 16'd2048;

  // Five 16-bit terms need three guard bits; the magnitude one fewer.
  localparam int SUM_W        = SAMPLE_W + 3;
  localparam int MAG_W        = SAMPLE_W + 2;
  // ceil(2^20 / 5): exact floor division for magnitudes below 2^18
  localparam int DIV5_SHIFT   = 20;
  localparam int DIV5_MAGIC_W = 18;
  localparam logic [DIV5_MAGIC_W-1:0] DIV5_MAGIC = 18'd209716;
  localparam int PROD_W       = MAG_W + DIV5_MAGIC_W;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] height;
    logic                       last_of_run;
    logic                       end_of_frame;
  } result_t;

endpackage

`default_nettype wire

>>> design/fpcm_stream_if.sv
// Valid/ready stream interfaces for samples in and results out.
`default_nettype none

interface fpcm_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [fpcm_pkg::SAMPLE_W-1:0] height_sample;

  modport source (output valid, output height_sample, input ready);
  modport sink   (input valid, input height_sample, output ready);
endinterface

interface fpcm_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [fpcm_pkg::SAMPLE_W-1:0] smoothed_height;
  logic                                 last_of_run;
  logic                                 end_of_frame;

  modport source (output valid, output smoothed_height, output last_of_run,
                  output end_of_frame, input ready);
  modport sink   (input valid, input smoothed_height, input last_of_run,
                  input end_of_frame, output ready);
endinterface

`default_nettype wire

>>> design/fpcm_linebuf.sv
// Two line buffers holding the previous and the older row, registered reads.
`default_nettype none

module fpcm_linebuf #(
  parameter int MAX_ROW_LENGTH = fpcm_pkg::MAX_ROW_LENGTH_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 req_en,
  input  wire logic [$clog2(MAX_ROW_LENGTH)-1:0]    col,
  input  wire logic [$clog2(MAX_ROW_LENGTH)-1:0]    col_right,
  input  wire logic signed [fpcm_pkg::SAMPLE_W-1:0] cur,
  input  wire logic                                 old_we,
  input  wire logic [$clog2(MAX_ROW_LENGTH)-1:0]    old_addr,
  output logic signed [fpcm_pkg::SAMPLE_W-1:0]      mid,
  output logic signed [fpcm_pkg::SAMPLE_W-1:0]      right,
  output logic signed [fpcm_pkg::SAMPLE_W-1:0]      up
);

  localparam int CW    = $clog2(MAX_ROW_LENGTH);
  localparam int DEPTH = 2 ** CW;

  logic signed [fpcm_pkg::SAMPLE_W-1:0] prev_mem [DEPTH];
  logic signed [fpcm_pkg::SAMPLE_W-1:0] old_mem  [DEPTH];
  logic signed [fpcm_pkg::SAMPLE_W-1:0] mid_r, right_r, up_r;

  // Previous row: read at this column and the next, then overwrite this column.
  always_ff @(posedge clk) begin
    if (req_en) begin
      mid_r         <= prev_mem[col];
      right_r       <= prev_mem[col_right];
      prev_mem[col] <= cur;
    end
  end

  // Older row takes the previous-row value one stage later.
  always_ff @(posedge clk) begin
    if (req_en) begin
      up_r <= old_mem[col];
    end
    if (old_we) begin
      old_mem[old_addr] <= mid_r;
    end
  end

  assign mid   = mid_r;
  assign right = right_r;
  assign up    = up_r;

endmodule

`default_nettype wire

>>> design/fpcm_div5.sv
// Divide a sign-magnitude sum by five, truncating toward zero.
`default_nettype none

module fpcm_div5 (
  input  wire logic                               neg,
  input  wire logic [fpcm_pkg::MAG_W-1:0]         mag,
  output logic signed [fpcm_pkg::SAMPLE_W-1:0]    quot
);

  logic [fpcm_pkg::PROD_W-1:0]   prod;
  logic [fpcm_pkg::SAMPLE_W-1:0] q_mag;

  always_comb begin
    prod  = fpcm_pkg::PROD_W'(mag) * fpcm_pkg::PROD_W'(fpcm_pkg::DIV5_MAGIC);
    q_mag = prod[fpcm_pkg::DIV5_SHIFT +: fpcm_pkg::SAMPLE_W];
    quot  = neg ? -q_mag : q_mag;
  end

endmodule

`default_nettype wire

>>> design/fpcm_outq.sv
// Output register that presents one or two results per request in order.
`default_nettype none

module fpcm_outq (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire logic              has_second,
  input  fpcm_pkg::result_t      first,
  input  fpcm_pkg::result_t      second,
  output logic                   free,
  fpcm_out_if.source             out_stream
);

  logic              v_r, has2_r, show2_r;
  fpcm_pkg::result_t a_r, b_r;
  fpcm_pkg::result_t shown;
  logic              drain_done;

  assign drain_done = v_r && out_stream.ready && (!has2_r || show2_r);
  assign free       = !v_r || drain_done;
  assign shown      = show2_r ? b_r : a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r     <= 1'b0;
      has2_r  <= 1'b0;
      show2_r <= 1'b0;
    end else if (load && free) begin
      v_r     <= 1'b1;
      has2_r  <= has_second;
      show2_r <= 1'b0;
    end else if (drain_done) begin
      v_r     <= 1'b0;
    end else if (v_r && out_stream.ready) begin
      show2_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load && free) begin
      a_r <= first;
      b_r <= second;
    end
  end

  assign out_stream.valid           = v_r;
  assign out_stream.smoothed_height = shown.height;
  assign out_stream.last_of_run     = shown.last_of_run;
  assign out_stream.end_of_frame    = shown.end_of_frame;

endmodule

`default_nettype wire

>>> design/five_point_cross_mean_filter_top.sv
// An accepted sample passes stage 1, stage 2 and then the output register.
// Throughput: one sample per cycle while the output is not stalled; in the
// last row each sample's two results share one output register; input waits.
// Line buffers have one write and registered reads, giving the three stages.
// Reset (rst_n low, synchronous) clears positions and stage valids and sets
// both size registers to 2048; line buffer contents are left as they are.
`default_nettype none

module five_point_cross_mean_filter_top #(
  parameter int MAX_ROW_LENGTH = fpcm_pkg::MAX_ROW_LENGTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  fpcm_in_if.sink                                 in_stream,
  fpcm_out_if.source                              out_stream,
  input  wire logic                               cfg_we,
  input  wire logic [fpcm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [fpcm_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int CW = $clog2(MAX_ROW_LENGTH);
  localparam int LW = (CW + 1 > fpcm_pkg::ROW_LENGTH_W) ? CW + 1 : fpcm_pkg::ROW_LENGTH_W;
  localparam int RW = fpcm_pkg::ROW_COUNT_W;
  localparam int SW = fpcm_pkg::SAMPLE_W;

  typedef struct packed {
    logic has_res;
    logic last_row;
    logic interior;
    logic last_col;
  } flags_t;

  // configuration
  logic [fpcm_pkg::ROW_LENGTH_W-1:0] row_length_r;
  logic [RW-1:0]                     row_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_length_r <= fpcm_pkg::ROW_LENGTH_RST;
      row_count_r  <= fpcm_pkg::ROW_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fpcm_pkg::REG_ROW_LENGTH: begin
          row_length_r <= cfg_data[fpcm_pkg::ROW_LENGTH_W-1:0];
        end
        fpcm_pkg::REG_ROW_COUNT: begin
          row_count_r <= cfg_data[RW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  logic [LW-1:0] rl_ext, len_eff;
  logic [RW-1:0] cnt_eff;

  always_comb begin
    rl_ext = LW'(row_length_r);
    if (rl_ext < LW'(fpcm_pkg::MIN_DIM)) begin
      len_eff = LW'(fpcm_pkg::MIN_DIM);
    end else if (rl_ext > LW'(MAX_ROW_LENGTH)) begin
      len_eff = LW'(MAX_ROW_LENGTH);
    end else begin
      len_eff = rl_ext;
    end
    cnt_eff = (row_count_r < RW'(fpcm_pkg::MIN_DIM)) ? RW'(fpcm_pkg::MIN_DIM) : row_count_r;
  end

  // raster position
  logic [CW-1:0] col_r, col_nxt, c_cur;
  logic [RW-1:0] row_r, row_nxt, r_pre, r_cur, r_inc;
  logic [LW-1:0] c_inc;
  logic          wrap_c, end_row, in_fire;
  flags_t        flags_in;

  assign in_fire = in_stream.valid && in_stream.ready;

  always_comb begin
    // a size change while idle may leave the position past the new end
    wrap_c  = LW'(col_r) >= len_eff;
    c_cur   = wrap_c ? '0 : col_r;
    r_pre   = wrap_c ? row_r + RW'(1) : row_r;
    r_cur   = (r_pre >= cnt_eff) ? '0 : r_pre;
    c_inc   = LW'(c_cur) + LW'(1);
    end_row = c_inc >= len_eff;
    r_inc   = r_cur + RW'(1);
    col_nxt = end_row ? '0 : c_inc[CW-1:0];
    row_nxt = end_row ? ((r_inc >= cnt_eff) ? '0 : r_inc) : r_cur;

    flags_in.has_res  = r_cur != '0;
    flags_in.last_row = r_cur == (cnt_eff - RW'(1));
    flags_in.last_col = end_row;
    flags_in.interior = (r_cur >= RW'(2)) && (c_cur != '0) && !end_row;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_fire) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // pipeline handshake
  logic s1_v_r, s2_v_r;
  flags_t s1_f_r, s2_f_r;
  logic out_free, s2_fire, s2_free, s1_fire, s1_free;

  assign s2_fire = s2_v_r && (!s2_f_r.has_res || out_free);
  assign s2_free = !s2_v_r || s2_fire;
  assign s1_fire = s1_v_r && s2_free;
  assign s1_free = !s1_v_r || s1_fire;
  assign in_stream.ready = s1_free;

  // stage 1: line buffer reads
  logic signed [SW-1:0] lb_mid, lb_right, lb_up;
  logic signed [SW-1:0] s1_cur_r, left_r;
  logic [CW-1:0]        s1_c_r;

  fpcm_linebuf #(
    .MAX_ROW_LENGTH (MAX_ROW_LENGTH)
  ) u_linebuf (
    .clk       (clk),
    .req_en    (in_fire),
    .col       (c_cur),
    .col_right (c_inc[CW-1:0]),
    .cur       (in_stream.height_sample),
    .old_we    (s1_fire),
    .old_addr  (s1_c_r),
    .mid       (lb_mid),
    .right     (lb_right),
    .up        (lb_up)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_free) begin
      s1_v_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cur_r <= in_stream.height_sample;
      s1_c_r   <= c_cur;
      s1_f_r   <= flags_in;
    end
    // previous-row value at the column before, kept for the left neighbour
    if (s1_fire) begin
      left_r <= lb_mid;
    end
  end

  logic signed [fpcm_pkg::SUM_W-1:0] sum, sum_abs;

  always_comb begin
    sum = fpcm_pkg::SUM_W'(lb_mid) + fpcm_pkg::SUM_W'(left_r) + fpcm_pkg::SUM_W'(lb_right)
        + fpcm_pkg::SUM_W'(lb_up) + fpcm_pkg::SUM_W'(s1_cur_r);
    sum_abs = sum[fpcm_pkg::SUM_W-1] ? -sum : sum;
  end

  // stage 2: sign and magnitude of the sum
  logic                        s2_neg_r;
  logic [fpcm_pkg::MAG_W-1:0]  s2_mag_r;
  logic signed [SW-1:0]        s2_mid_r, s2_cur_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_free) begin
      s2_v_r <= s1_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      s2_neg_r <= sum[fpcm_pkg::SUM_W-1];
      s2_mag_r <= sum_abs[fpcm_pkg::MAG_W-1:0];
      s2_mid_r <= lb_mid;
      s2_cur_r <= s1_cur_r;
      s2_f_r   <= s1_f_r;
    end
  end

  // stage 3: divide and hand the results to the output register
  logic signed [SW-1:0] quot;
  fpcm_pkg::result_t    res_a, res_b;

  fpcm_div5 u_div5 (
    .neg  (s2_neg_r),
    .mag  (s2_mag_r),
    .quot (quot)
  );

  always_comb begin
    res_a.height       = s2_f_r.interior ? quot : s2_mid_r;
    res_a.last_of_run  = !s2_f_r.last_row;
    res_a.end_of_frame = 1'b0;
    res_b.height       = s2_cur_r;
    res_b.last_of_run  = 1'b1;
    res_b.end_of_frame = s2_f_r.last_col;
  end

  fpcm_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (s2_v_r && s2_f_r.has_res),
    .has_second (s2_f_r.last_row),
    .first      (res_a),
    .second     (res_b),
    .free       (out_free),
    .out_stream (out_stream)
  );

endmodule

`default_nettype wire

>>> design/fpcm_checker.sv
// Port-level checker for the filter top, attached by bind.
`default_nettype none
`include "assert_macros.svh"

module fpcm_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [fpcm_pkg::SAMPLE_W-1:0] out_height,
  input wire logic                          out_last,
  input wire logic                          out_eof
);

  logic [fpcm_pkg::SAMPLE_W+1:0] out_word;

  assign out_word = {out_height, out_last, out_eof};

  `FPCM_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `FPCM_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_word), "result changed")
  `FPCM_ASSERT(a_eof_last, out_valid && out_eof |-> out_last, "frame end not on final result")
  `FPCM_ASSERT(a_backpressure, !in_ready |-> out_valid, "input stalled with no result waiting")
  `FPCM_ASSERT_RST(a_reset, !rst_n |=> in_ready && !out_valid, "reset left the pipeline busy")

endmodule

bind five_point_cross_mean_filter_top fpcm_checker u_fpcm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_stream.ready),
  .out_valid  (out_stream.valid),
  .out_ready  (out_stream.ready),
  .out_height (out_stream.smoothed_height),
  .out_last   (out_stream.last_of_run),
  .out_eof    (out_stream.end_of_frame)
);

`default_nettype wire

>>> tb/tb_five_point_cross_mean_filter_top.sv
`timescale 1ns / 1ps
// Self-checking bench of the five-point cross mean filter with a cycle-free grid predictor.

typedef logic signed [fpcm_pkg::SAMPLE_W-1:0] height_t;

class height_smoother;
  height_t                              upper_row [fpcm_pkg::MAX_ROW_LENGTH_DEF];
  height_t                              prior_row [fpcm_pkg::MAX_ROW_LENGTH_DEF];
  int unsigned                          row_pos;
  int unsigned                          col_pos;
  logic [fpcm_pkg::ROW_LENGTH_W-1:0]    len_reg;
  logic [fpcm_pkg::ROW_COUNT_W-1:0]     count_reg;
  fpcm_pkg::result_t                    due_heights [$];
  int unsigned                          compared;
  int unsigned                          mismatches;

  function new();
    foreach (upper_row[i]) begin
      upper_row[i] = '0;
      prior_row[i] = '0;
    end
    row_pos    = 0;
    col_pos    = 0;
    len_reg    = fpcm_pkg::ROW_LENGTH_RST;
    count_reg  = fpcm_pkg::ROW_COUNT_RST;
    compared   = 0;
    mismatches = 0;
  endfunction

  static function int unsigned clamp_len(int unsigned value);
    if (value < fpcm_pkg::MIN_DIM) return fpcm_pkg::MIN_DIM;
    if (value > fpcm_pkg::MAX_ROW_LENGTH_DEF) return fpcm_pkg::MAX_ROW_LENGTH_DEF;
    return value;
  endfunction

  static function int unsigned clamp_cnt(int unsigned value);
    return (value < fpcm_pkg::MIN_DIM) ? fpcm_pkg::MIN_DIM : value;
  endfunction

  function int unsigned eff_len();
    return clamp_len(32'(len_reg));
  endfunction

  function void write_reg(logic [fpcm_pkg::CFG_IDX_W-1:0] index,
                          logic [fpcm_pkg::CFG_DATA_W-1:0] data);
    case (index)
      fpcm_pkg::REG_ROW_LENGTH: len_reg   = data[fpcm_pkg::ROW_LENGTH_W-1:0];
      fpcm_pkg::REG_ROW_COUNT:  count_reg = data[fpcm_pkg::ROW_COUNT_W-1:0];
      default: ;
    endcase
  endfunction

  function bit mid_frame();
    return row_pos != 0 || col_pos != 0;
  endfunction

  // A longer row is only allowed once the grid is back in its first row, so
  // that every line buffer entry read later has been written since reset.
  function bit length_change_safe(logic [fpcm_pkg::CFG_DATA_W-1:0] len_data,
                                  logic [fpcm_pkg::CFG_DATA_W-1:0] cnt_data);
    int unsigned new_len;
    int unsigned new_cnt;
    int unsigned r;
    new_len = clamp_len(32'(len_data[fpcm_pkg::ROW_LENGTH_W-1:0]));
    new_cnt = clamp_cnt(32'(cnt_data[fpcm_pkg::ROW_COUNT_W-1:0]));
    r = row_pos;
    if (col_pos >= new_len) r++;
    if (r >= new_cnt) r = 0;
    return new_len <= eff_len() || r == 0;
  endfunction

  // Samples still needed to close the grid under the present sizes.
  function int unsigned frame_left();
    int unsigned len;
    int unsigned cnt;
    int unsigned r;
    int unsigned c;
    len = eff_len();
    cnt = clamp_cnt(32'(count_reg));
    r = row_pos;
    c = col_pos;
    if (c >= len) begin
      c = 0;
      r++;
    end
    if (r >= cnt) r = 0;
    return (cnt - r) * len - c;
  endfunction

  function void take_sample(height_t height);
    int unsigned       len;
    int unsigned       cnt;
    int unsigned       c;
    int unsigned       r;
    int                total;
    bit                bottom;
    fpcm_pkg::result_t res;
    len = eff_len();
    cnt = clamp_cnt(32'(count_reg));
    if (col_pos >= len) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= cnt) row_pos = 0;
    c = col_pos;
    r = row_pos;
    if (r > 0) begin
      bottom = (r == cnt - 1);
      res.height = prior_row[c];
      if (r >= 2 && c > 0 && c < len - 1) begin
        // upper_row[c-1] already carries the row above, shifted this row
        total = int'(prior_row[c]) + int'(upper_row[c-1]) + int'(prior_row[c+1])
              + int'(upper_row[c]) + int'(height);
        res.height = height_t'(total / 5);
      end
      res.last_of_run  = !bottom;
      res.end_of_frame = 1'b0;
      due_heights.push_back(res);
      if (bottom) begin
        res.height       = height;
        res.last_of_run  = 1'b1;
        res.end_of_frame = (c == len - 1);
        due_heights.push_back(res);
      end
    end
    upper_row[c] = prior_row[c];
    prior_row[c] = height;
    col_pos = c + 1;
    if (col_pos >= len) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= cnt) row_pos = 0;
    end
  endfunction

  function void check_result(fpcm_pkg::result_t got);
    fpcm_pkg::result_t want;
    compared++;
    if (due_heights.size() == 0) begin
      mismatches++;
      $error("smoothed_height: no result due, got %0d", got.height);
      return;
    end
    want = due_heights.pop_front();
    if (got.height !== want.height) begin
      mismatches++;
      $error("smoothed_height: expected %0d, got %0d", want.height, got.height);
    end
    if (got.last_of_run !== want.last_of_run) begin
      mismatches++;
      $error("last_of_run: expected %0b, got %0b", want.last_of_run, got.last_of_run);
    end
    if (got.end_of_frame !== want.end_of_frame) begin
      mismatches++;
      $error("end_of_frame: expected %0b, got %0b", want.end_of_frame, got.end_of_frame);
    end
  endfunction
endclass

module tb_five_point_cross_mean_filter_top;

  localparam int RANDOM_SAMPLES = 700;
  localparam int HOLD_CYCLES    = 300;

  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            cfg_we    = 1'b0;
  logic [fpcm_pkg::CFG_IDX_W-1:0]  cfg_index = fpcm_pkg::REG_ROW_LENGTH;
  logic [fpcm_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
  bit                    steady     = 1'b0;
  bit                    hold_asked = 1'b0;
  int unsigned           samples_sent  = 0;
  int unsigned           settings_used = 0;
  int unsigned           reshapes      = 0;
  int unsigned           widest        = 0;
  height_smoother        smoother;
  fpcm_pkg::result_t     seen;
  height_t               directed_heights [21];

  fpcm_in_if  in_if ();
  fpcm_out_if out_if ();

  five_point_cross_mean_filter_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stream  (in_if),
    .out_stream (out_if),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic height_t random_height();
    case ($urandom_range(15))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return '0;
      3:       return '1;
      default: return height_t'($urandom);
    endcase
  endfunction

  task automatic configure(input logic [fpcm_pkg::CFG_DATA_W-1:0] len_data,
                           input logic [fpcm_pkg::CFG_DATA_W-1:0] cnt_data);
    if (smoother.mid_frame()) reshapes++;
    settings_used++;
    cfg_we    <= 1'b1;
    cfg_index <= fpcm_pkg::REG_ROW_LENGTH;
    cfg_data  <= len_data;
    @(posedge clk);
    smoother.write_reg(fpcm_pkg::REG_ROW_LENGTH, len_data);
    @(negedge clk);
    cfg_index <= fpcm_pkg::REG_ROW_COUNT;
    cfg_data  <= cnt_data;
    @(posedge clk);
    smoother.write_reg(fpcm_pkg::REG_ROW_COUNT, cnt_data);
    @(negedge clk);
    cfg_we <= 1'b0;
    if (smoother.eff_len() > widest) widest = smoother.eff_len();
  endtask

  task automatic send_sample(input height_t height);
    while (!steady && $urandom_range(99) < 30) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.height_sample <= height;
    // hold the request until the filter takes it
    do @(posedge clk); while (!in_if.ready);
    smoother.take_sample(height);
    samples_sent++;
    @(negedge clk);
  endtask

  // First-row samples give no result, so allow for the pipeline after the
  // last expected result before touching the size registers.
  task automatic wait_idle();
    while (smoother.due_heights.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Result side: random back-pressure, plus one long hold-off on request.
  initial begin
    int unsigned hold_left;
    bit          hold_done;
    hold_left    = 0;
    hold_done    = 1'b0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_asked && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= steady || ($urandom_range(99) >= 30);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      seen.height       = out_if.smoothed_height;
      seen.last_of_run  = out_if.last_of_run;
      seen.end_of_frame = out_if.end_of_frame;
      smoother.check_result(seen);
    end
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    logic [fpcm_pkg::CFG_DATA_W-1:0] len_data;
    logic [fpcm_pkg::CFG_DATA_W-1:0] cnt_data;
    int unsigned           left;
    int unsigned           count;
    int unsigned           random_sent;
    smoother = new();
    in_if.valid         = 1'b0;
    in_if.height_sample = '0;
    // 3x3 grid whose centre averages to the most negative value, then a 4x3
    // grid with a full-scale centre and a small negative sum that truncates
    directed_heights = '{
      16'sh7FFF, 16'sh8000, 16'sh5555,
      16'sh8000, 16'sh8000, 16'sh8000,
      16'shAAAA, 16'sh8000, 16'sh0000,
      16'sd1,    16'sh7FFF, 16'sh8000, 16'sd2,
      16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000,
      -16'sd1,   16'sh7FFF, -16'sd5,   16'sd0
    };
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // sizes below the minimum clamp to 3
    configure(16'd2, 16'd0);
    for (int k = 0; k < 9; k++) send_sample(directed_heights[k]);
    in_if.valid <= 1'b0;
    wait_idle();
    configure(16'd4, 16'd3);
    for (int k = 9; k < 21; k++) send_sample(directed_heights[k]);
    in_if.valid <= 1'b0;
    wait_idle();

    // mid-size grid; output stalls long early on, later a stretch with no idling
    configure(16'd32, 16'd20);
    left = smoother.frame_left();
    for (int k = 0; k < left; k++) begin
      if (k == 100) hold_asked = 1'b1;
      steady = (k >= 300 && k < 550);
      send_sample(random_height());
    end
    steady = 1'b0;
    in_if.valid <= 1'b0;
    wait_idle();

    random_sent = 0;
    while (random_sent < RANDOM_SAMPLES) begin
      case ($urandom_range(9))
        0: begin
          case ($urandom_range(5))
            0:       len_data = 16'd0;
            1:       len_data = 16'd1;
            2:       len_data = 16'd2;
            3:       len_data = 16'd2048;
            4:       len_data = 16'd2049;
            default: len_data = 16'd4095;
          endcase
        end
        1:       len_data = fpcm_pkg::CFG_DATA_W'($urandom_range(13, 64));
        default: len_data = fpcm_pkg::CFG_DATA_W'($urandom_range(3, 12));
      endcase
      // bits above the register width are dropped
      if ($urandom_range(7) == 0) begin
        len_data[fpcm_pkg::CFG_DATA_W-1:fpcm_pkg::ROW_LENGTH_W] = 4'($urandom);
      end
      case ($urandom_range(9))
        0: begin
          case ($urandom_range(4))
            0:       cnt_data = 16'd0;
            1:       cnt_data = 16'd1;
            2:       cnt_data = 16'd2;
            3:       cnt_data = 16'hFFFF;
            default: cnt_data = 16'($urandom);
          endcase
        end
        default: cnt_data = fpcm_pkg::CFG_DATA_W'($urandom_range(3, 8));
      endcase
      if (!smoother.length_change_safe(len_data, cnt_data)) begin
        len_data = fpcm_pkg::CFG_DATA_W'(smoother.len_reg);
      end
      configure(len_data, cnt_data);
      left = smoother.frame_left();
      // mostly whole grids; the rest stop part way and get resized
      if (left <= 400 && $urandom_range(3) != 0) count = left;
      else count = $urandom_range(1, (left < 40) ? left : 40);
      repeat (count) send_sample(random_height());
      in_if.valid <= 1'b0;
      random_sent += count;
      wait_idle();
    end

    $display("Sent %0d samples under %0d grid sizes (%0d resized inside a grid), widest row %0d.",
             samples_sent, settings_used, reshapes, widest);
    $display("Compared %0d results, %0d field mismatches.",
             smoother.compared, smoother.mismatches);
    if (smoother.mismatches == 0 && smoother.due_heights.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/fpcm_pkg.sv
design/fpcm_stream_if.sv
design/fpcm_linebuf.sv
design/fpcm_div5.sv
design/fpcm_outq.sv
design/five_point_cross_mean_filter_top.sv
design/fpcm_checker.sv
tb/tb_five_point_cross_mean_filter_top.sv
